// ----- rtl/page_framebuffer_glyph_drawer_assert.svh -----
// Assertion helpers used by the top RTL file of the glyph drawer.
`ifndef PAGE_FRAMEBUFFER_GLYPH_DRAWER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_GLYPH_DRAWER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFGD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pfgd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PFGD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pfgd: next-cycle check failed");

`endif

// ----- rtl/pfgd_pkg.sv -----
`default_nettype none
package pfgd_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_PIXEL = 3'd1,
        CMD_GLYPH = 3'd2,
        CMD_LINE  = 3'd3,
        CMD_FONT  = 3'd4,
        CMD_FLUSH = 3'd5
    } cmd_code_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_FONT_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FONT_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_FIRST_CODE   = 3'd2;
    localparam logic [2:0] REG_FONT_SPACING = 3'd3;
    localparam logic [2:0] REG_COLUMN_LIMIT = 3'd4;
    localparam logic [2:0] REG_CONTROL_BYTE = 3'd5;

    localparam logic [4:0] MAX_WIDTH  = 5'd16;
    localparam logic [3:0] MAX_HEIGHT = 4'd8;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_FRD,
        B_FUSE,
        B_RD,
        B_WR,
        B_CTL,
        B_FLRD,
        B_FLOUT
    } bstate_t;

    typedef struct packed {
        logic [4:0] width;
        logic [3:0] height;
        logic [7:0] first_code;
        logic [3:0] spacing;
        logic [7:0] column_limit;
        logic [7:0] control_byte;
    } cfg_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        cmd_code_t           kind;
        logic [7:0]          x;
        logic [7:0]          y;
        logic                on;
        logic signed [14:0]  base;
        logic [11:0]         start;
        logic [2:0]          line;
        logic [10:0]         faddr;
        logic [7:0]          fbyte;
    } cmd_t;

    typedef struct packed {
        logic [63:0] data;
        logic        is_control;
        logic        last;
    } word_t;

    function automatic logic [4:0] eff_width(input logic [4:0] w);
        return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    function automatic logic [3:0] eff_height(input logic [3:0] h);
        return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pfgd_ram.sv -----
`default_nettype none
module pfgd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/pfgd_front.sv -----
`default_nettype none
module pfgd_front #(
    parameter int unsigned COLUMNS    = 128,
    parameter int unsigned PAGES      = 8,
    parameter int unsigned FONT_DEPTH = 2048
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [63:0]     s_tdata,
    input  wire logic [2:0]      s_tuser,
    input  wire pfgd_pkg::cfg_t  cfg,
    output logic                 q_valid,
    output pfgd_pkg::cmd_t       q_cmd,
    input  wire logic            q_pop
);

    logic [7:0]          f_x, f_y, f_char, f_fbyte;
    logic                f_on;
    logic [2:0]          f_tline, f_page;
    logic [6:0]          f_pos;
    logic [10:0]         f_faddr;
    logic [4:0]          fw;
    logic [11:0]         prod;
    logic signed [8:0]   diff;
    logic                keep;
    pfgd_pkg::cmd_code_t code;
    pfgd_pkg::cmd_t      entry;
    pfgd_pkg::cmd_t      q_mem_reg [2];
    logic                wptr_reg, rptr_reg;
    logic [1:0]          count_reg;
    logic                push;

    // Field unpacking.
    assign f_x     = s_tdata[7:0];
    assign f_y     = s_tdata[15:8];
    assign f_on    = s_tdata[16];
    assign f_char  = s_tdata[24:17];
    assign f_tline = s_tdata[27:25];
    assign f_pos   = s_tdata[34:28];
    assign f_faddr = s_tdata[45:35];
    assign f_fbyte = s_tdata[53:46];
    assign f_page  = s_tdata[56:54];
    assign code    = pfgd_pkg::cmd_code_t'(s_tuser);

    assign fw   = pfgd_pkg::eff_width(cfg.width);
    assign prod = 12'(f_pos) * 12'(fw);
    assign diff = $signed({1'b0, f_char}) - $signed({1'b0, cfg.first_code});

    // Classify: build the queue entry and drop commands with no effect.
    always_comb begin
        entry.kind  = code;
        entry.x     = f_x;
        entry.y     = f_y;
        entry.on    = f_on;
        entry.base  = $signed({{6{diff[8]}}, diff}) * $signed({10'b0, fw});
        entry.start = prod + 12'(cfg.spacing);
        entry.line  = (code == pfgd_pkg::CMD_FLUSH) ? f_page : f_tline;
        entry.faddr = f_faddr;
        entry.fbyte = f_fbyte;
        case (code)
            pfgd_pkg::CMD_CLEAR: keep = 1'b1;
            pfgd_pkg::CMD_PIXEL: keep = 1'b1;
            pfgd_pkg::CMD_GLYPH: keep = (fw != 5'd0);
            pfgd_pkg::CMD_LINE:  keep = (fw != 5'd0) && (int'(f_tline) < PAGES) &&
                                        (int'(prod) + int'(fw) <= COLUMNS);
            pfgd_pkg::CMD_FONT:  keep = (int'(f_faddr) < FONT_DEPTH);
            pfgd_pkg::CMD_FLUSH: keep = (int'(f_page) < PAGES);
            default:             keep = 1'b0;
        endcase
    end

    // Two-entry queue toward the back end.
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pfgd_back.sv -----
`default_nettype none
module pfgd_back #(
    parameter int unsigned COLUMNS    = 128,
    parameter int unsigned PAGES      = 8,
    parameter int unsigned FONT_DEPTH = 2048
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pfgd_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire pfgd_pkg::cmd_t  q_cmd,
    output logic                 q_pop,
    input  wire logic            out_ready,
    output logic                 out_load,
    output pfgd_pkg::word_t      out_word
);

    localparam int unsigned WORDS = (COLUMNS + 7) / 8;
    localparam int unsigned ROWS  = PAGES * WORDS;
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned FAW   = $clog2(FONT_DEPTH);
    localparam int unsigned KW    = $clog2(WORDS);

    // One byte update of a frame word.
    typedef struct packed {
        logic [RW-1:0] row;
        logic [2:0]    lane;
        logic [7:0]    mask;
        logic [7:0]    val;
        logic          en;
    } fop_t;

    pfgd_pkg::bstate_t state_reg, state_next;
    pfgd_pkg::cmd_t    cur_reg;
    logic [4:0]        col_reg;
    logic [KW-1:0]     k_reg;
    logic              fok_reg, second_reg;
    fop_t              op_reg, opb_reg;
    logic [ROWS-1:0]   valid_reg;

    logic [4:0]          fw;
    logic [3:0]          fh;
    logic signed [14:0]  fa;
    logic                fok;
    logic [7:0]          fbyte;
    logic [7:0]          font_rdata;
    logic [63:0]         fr_rdata, fr_old, fr_wdata;
    logic [RW-1:0]       flush_row, fr_raddr;
    logic                fr_re, fr_we, font_we, clr, k_last;
    fop_t                pix_op, fuse_a, fuse_b;
    logic                fuse_second;
    logic [7:0]          xc, yend;
    logic [4:0]          pa, pb;
    logic                xok;
    logic [11:0]         lc;
    logic [15:0]         bits_a, bits_b;

    // Mask and value bits of one glyph column within page pp.
    function automatic logic [15:0] page_bits(input logic [4:0] pp, input logic [7:0] y0,
                                              input logic [3:0] hgt, input logic [7:0] fb);
        logic [7:0] m;
        logic [7:0] v;
        logic [7:0] j;
        m = '0;
        v = '0;
        for (int b = 0; b < 8; b++) begin
            j    = {pp, 3'(b)} - y0;
            m[b] = (j < {4'b0, hgt});
            v[b] = fb[j[2:0]] & m[b];
        end
        return {m, v};
    endfunction

    assign fw = pfgd_pkg::eff_width(cfg.width);
    assign fh = pfgd_pkg::eff_height(cfg.height);

    // Font address of the current glyph column.
    assign fa  = cur_reg.base + $signed({10'b0, col_reg});
    assign fok = (fa >= 0) && (int'(fa) < FONT_DEPTH);
    assign fbyte = fok_reg ? font_rdata : 8'h00;

    // Single pixel update taken straight from the queue head.
    always_comb begin
        pix_op.row  = RW'(int'(q_cmd.y[7:3]) * WORDS + int'(q_cmd.x[7:3]));
        pix_op.lane = q_cmd.x[2:0];
        pix_op.mask = 8'h01 << q_cmd.y[2:0];
        pix_op.val  = q_cmd.on ? pix_op.mask : 8'h00;
        pix_op.en   = (q_cmd.x < cfg.column_limit) && (int'(q_cmd.x) < COLUMNS) &&
                      (int'(q_cmd.y) < PAGES * 8);
    end

    // Column updates once the font byte is back.
    always_comb begin
        xc     = cur_reg.x + 8'(col_reg);
        xok    = (xc < cfg.column_limit) && (int'(xc) < COLUMNS);
        yend   = cur_reg.y + 8'(fh) - 8'd1;
        pa     = cur_reg.y[7:3];
        pb     = yend[7:3];
        bits_a = page_bits(pa, cur_reg.y, fh, fbyte);
        bits_b = page_bits(pb, cur_reg.y, fh, fbyte);
        lc     = cur_reg.start + 12'(col_reg);
        if (cur_reg.kind == pfgd_pkg::CMD_LINE) begin
            fuse_a.row  = RW'(int'(cur_reg.line) * WORDS + int'(lc[11:3]));
            fuse_a.lane = lc[2:0];
            fuse_a.mask = 8'hFF;
            fuse_a.val  = fbyte;
            fuse_a.en   = (int'(lc) < COLUMNS);
            fuse_second = 1'b0;
        end else begin
            fuse_a.row  = RW'(int'(pa) * WORDS + int'(xc[7:3]));
            fuse_a.lane = xc[2:0];
            fuse_a.mask = bits_a[15:8];
            fuse_a.val  = bits_a[7:0];
            fuse_a.en   = xok && (int'(pa) < PAGES);
            fuse_second = (pb != pa);
        end
        fuse_b.row  = RW'(int'(pb) * WORDS + int'(xc[7:3]));
        fuse_b.lane = xc[2:0];
        fuse_b.mask = bits_b[15:8];
        fuse_b.val  = bits_b[7:0];
        fuse_b.en   = xok && (int'(pb) < PAGES);
    end

    // Read-modify-write of one byte lane; unwritten rows read as zero.
    always_comb begin
        fr_old   = valid_reg[op_reg.row] ? fr_rdata : 64'h0;
        fr_wdata = fr_old;
        for (int l = 0; l < 8; l++) begin
            if (op_reg.lane == 3'(l)) begin
                fr_wdata[l*8 +: 8] = (fr_old[l*8 +: 8] & ~op_reg.mask) |
                                     (op_reg.val & op_reg.mask);
            end
        end
    end

    assign flush_row = RW'(int'(cur_reg.line) * WORDS + int'(k_reg));
    assign k_last    = (k_reg == KW'(WORDS - 1));

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        out_word   = '0;
        case (state_reg)
            pfgd_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        pfgd_pkg::CMD_PIXEL: state_next = pfgd_pkg::B_RD;
                        pfgd_pkg::CMD_GLYPH: state_next = pfgd_pkg::B_FRD;
                        pfgd_pkg::CMD_LINE:  state_next = pfgd_pkg::B_FRD;
                        pfgd_pkg::CMD_FLUSH: state_next = pfgd_pkg::B_CTL;
                        default:             state_next = pfgd_pkg::B_IDLE;
                    endcase
                end
            end
            pfgd_pkg::B_FRD:  state_next = pfgd_pkg::B_FUSE;
            pfgd_pkg::B_FUSE: state_next = pfgd_pkg::B_RD;
            pfgd_pkg::B_RD:   state_next = pfgd_pkg::B_WR;
            pfgd_pkg::B_WR: begin
                if (second_reg) begin
                    state_next = pfgd_pkg::B_RD;
                end else if (cur_reg.kind == pfgd_pkg::CMD_PIXEL) begin
                    state_next = pfgd_pkg::B_IDLE;
                end else if ((col_reg + 5'd1) < fw) begin
                    state_next = pfgd_pkg::B_FRD;
                end else begin
                    state_next = pfgd_pkg::B_IDLE;
                end
            end
            pfgd_pkg::B_CTL: begin
                out_load            = out_ready;
                out_word.data       = {56'h0, cfg.control_byte};
                out_word.is_control = 1'b1;
                if (out_ready) begin
                    state_next = pfgd_pkg::B_FLRD;
                end
            end
            pfgd_pkg::B_FLRD: state_next = pfgd_pkg::B_FLOUT;
            pfgd_pkg::B_FLOUT: begin
                out_load      = out_ready;
                out_word.data = valid_reg[flush_row] ? fr_rdata : 64'h0;
                out_word.last = k_last;
                if (out_ready) begin
                    state_next = k_last ? pfgd_pkg::B_IDLE : pfgd_pkg::B_FLRD;
                end
            end
            default: state_next = pfgd_pkg::B_IDLE;
        endcase
    end

    assign clr     = q_pop && (q_cmd.kind == pfgd_pkg::CMD_CLEAR);
    assign font_we = q_pop && (q_cmd.kind == pfgd_pkg::CMD_FONT);
    assign fr_we   = (state_reg == pfgd_pkg::B_WR) && op_reg.en;
    assign fr_re   = (state_reg == pfgd_pkg::B_RD) || (state_reg == pfgd_pkg::B_FLRD);
    assign fr_raddr = (state_reg == pfgd_pkg::B_FLRD) ? flush_row : op_reg.row;

    // State register and per-row valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfgd_pkg::B_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clr) begin
                valid_reg <= '0;
            end else if (fr_we) begin
                valid_reg[op_reg.row] <= 1'b1;
            end
        end
    end

    // Working registers of the current command.
    always_ff @(posedge aclk) begin
        case (state_reg)
            pfgd_pkg::B_IDLE: begin
                if (q_valid) begin
                    cur_reg    <= q_cmd;
                    col_reg    <= 5'd0;
                    k_reg      <= '0;
                    op_reg     <= pix_op;
                    second_reg <= 1'b0;
                end
            end
            pfgd_pkg::B_FRD: fok_reg <= fok;
            pfgd_pkg::B_FUSE: begin
                op_reg     <= fuse_a;
                opb_reg    <= fuse_b;
                second_reg <= fuse_second;
            end
            pfgd_pkg::B_WR: begin
                if (second_reg) begin
                    op_reg     <= opb_reg;
                    second_reg <= 1'b0;
                end else begin
                    col_reg <= col_reg + 5'd1;
                end
            end
            pfgd_pkg::B_FLOUT: begin
                if (out_ready) begin
                    k_reg <= k_reg + KW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    pfgd_ram #(.WIDTH(64), .DEPTH(ROWS)) u_frame (
        .aclk  (aclk),
        .we    (fr_we),
        .waddr (op_reg.row),
        .wdata (fr_wdata),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    pfgd_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
        .aclk  (aclk),
        .we    (font_we),
        .waddr (FAW'(q_cmd.faddr)),
        .wdata (q_cmd.fbyte),
        .re    (state_reg == pfgd_pkg::B_FRD),
        .raddr (fa[FAW-1:0]),
        .rdata (font_rdata)
    );

endmodule
`default_nettype wire

// ----- rtl/page_framebuffer_glyph_drawer.sv -----
// Monochrome page framebuffer with glyph drawing and page flush.
// Commands enter on the s_ stream (command code in s_tuser) and are queued
// two deep, so the input keeps taking commands while earlier ones execute.
// Clear and font load act as the command leaves the queue. A pixel is one
// byte update; a glyph reads each column's font byte, then updates one byte,
// or two when its rows reach into a second page (one in line mode). Each
// byte update reads the registered frame memory first, then writes. A flush
// emits on the m_ stream the control byte (m_tuser high) and then one 64-bit
// word per eight columns, the last with m_tlast; each word is read from
// memory, then loaded into the output register. A stalled m_tready holds
// the output word and the flush sequencer; the queue keeps accepting until
// full. Reset empties the queue and marks every frame row as zero; the font
// memory holds no reset value. Configuration is written through
// cfg_we/cfg_index/cfg_wdata by the user while idle; the block does not enforce this.
`default_nettype none
`include "page_framebuffer_glyph_drawer_assert.svh"
module page_framebuffer_glyph_drawer #(
    parameter int unsigned COLUMNS    = 128,
    parameter int unsigned PAGES      = 8,
    parameter int unsigned FONT_DEPTH = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x, y, pixel_on, character, text_line, text_position, font_address,
    // font_byte, page
    input  wire logic [63:0] s_tdata,
    // command
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data
    output logic [63:0]      m_tdata,
    // is_control
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    pfgd_pkg::cfg_t  cfg_reg;
    pfgd_pkg::cmd_t  q_cmd;
    pfgd_pkg::word_t out_word;
    pfgd_pkg::word_t out_reg;
    logic            q_valid, q_pop;
    logic            out_load, out_ready;
    logic            m_valid_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width        <= 5'd8;
            cfg_reg.height       <= 4'd8;
            cfg_reg.first_code   <= 8'd32;
            cfg_reg.spacing      <= 4'd0;
            cfg_reg.column_limit <= 8'd126;
            cfg_reg.control_byte <= 8'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                pfgd_pkg::REG_FONT_WIDTH:   cfg_reg.width        <= cfg_wdata[4:0];
                pfgd_pkg::REG_FONT_HEIGHT:  cfg_reg.height       <= cfg_wdata[3:0];
                pfgd_pkg::REG_FIRST_CODE:   cfg_reg.first_code   <= cfg_wdata;
                pfgd_pkg::REG_FONT_SPACING: cfg_reg.spacing      <= cfg_wdata[3:0];
                pfgd_pkg::REG_COLUMN_LIMIT: cfg_reg.column_limit <= cfg_wdata;
                pfgd_pkg::REG_CONTROL_BYTE: cfg_reg.control_byte <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pfgd_front #(.COLUMNS(COLUMNS), .PAGES(PAGES), .FONT_DEPTH(FONT_DEPTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    pfgd_back #(.COLUMNS(COLUMNS), .PAGES(PAGES), .FONT_DEPTH(FONT_DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_ready (out_ready),
        .out_load  (out_load),
        .out_word  (out_word)
    );

    // Output register; a new word loads when the register is empty or the current one transfers.
    assign out_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_word;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_reg.data;
    assign m_tuser[0] = out_reg.is_control;
    assign m_tlast    = out_reg.last;

    // The control word never closes a page.
    `PFGD_ASSERT_IMP(a_ctl_not_last, aclk, aresetn, m_tvalid && m_tuser[0], !m_tlast)
    // The back end never overwrites a word that has not transferred.
    `PFGD_ASSERT_IMP(a_no_overwrite, aclk, aresetn, out_load && m_tvalid, m_tready)
    // After the last word of a page, the next word can only be a control word.
    `PFGD_ASSERT_NEXT(a_page_then_ctl, aclk, aresetn, m_tvalid && m_tready && m_tlast,
                      !m_tvalid || m_tuser[0])

endmodule
`default_nettype wire
